[rtl/core/cse_pkg.sv]
`default_nettype none
package cse_pkg;

  localparam int unsigned SlotsDefault = 32;

  localparam logic [1:0] OpCreate = 2'd0;
  localparam logic [1:0] OpAdd    = 2'd1;
  localparam logic [1:0] OpAccess = 2'd2;

  localparam logic [2:0] PolFifo = 3'd0;
  localparam logic [2:0] PolLru  = 3'd1;
  localparam logic [2:0] PolLfu  = 3'd2;
  localparam logic [2:0] PolMfu  = 3'd3;
  localparam logic [2:0] PolMru  = 3'd4;

  localparam logic [1:0] StOk     = 2'd0;
  localparam logic [1:0] StTooBig = 2'd1;
  localparam logic [1:0] StNoVict = 2'd2;

  localparam logic [1:0] CfgByteLimit  = 2'd0;
  localparam logic [1:0] CfgEntryLimit = 2'd1;
  localparam logic [1:0] CfgPolicy     = 2'd2;

  localparam logic [31:0] ByteLimitReset  = 32'd1048576;
  localparam logic [5:0]  EntryLimitReset = 6'd32;

  typedef struct packed {
    logic [1:0]  op;
    logic [4:0]  slot;
    logic [31:0] byte_count;
  } in_word_t;

  typedef struct packed {
    logic        kind;
    logic [4:0]  victim_slot;
    logic [31:0] victim_bytes;
    logic        last;
    logic [1:0]  status;
    logic [31:0] bytes_in_use;
    logic [5:0]  entries_in_use;
    logic [31:0] eviction_total;
  } out_word_t;

  // scan compare unit control
  typedef struct packed {
    logic        first;
    logic [2:0]  policy;
    logic [31:0] key;
  } cmp_req_t;

endpackage
`default_nettype wire

[rtl/core/cse_cmp.sv]
`default_nettype none
module cse_cmp (
  input  var cse_pkg::cmp_req_t req_i,
  input  wire logic [31:0]      best_key_i,
  output logic                  take_o
);
  always_comb begin
    case (req_i.policy)
      cse_pkg::PolLfu: take_o = req_i.first || (req_i.key <= best_key_i);
      cse_pkg::PolMfu: take_o = req_i.first || (req_i.key >= best_key_i);
      cse_pkg::PolMru: take_o = req_i.first || (req_i.key < best_key_i);
      default:         take_o = req_i.first || (req_i.key > best_key_i);
    endcase
  end
endmodule
`default_nettype wire

[rtl/core/capacity_limited_store_eviction.sv]
// each op is decoded and its slot read and checked; a rejected op goes straight to the final
// word, an applied op writes its slot and then issues the final word
// each eviction is a scan of all SLOTS slots, then victim read and an eviction report word
// add bytes with k evictions scans again after each one; one item at a time, in_stall_o is
// high until the block is idle again after the final word; output stalls hold the op
// reset clears valid bits, totals and clocks and sets config registers to their defaults; slot memories are not cleared
`default_nettype none
module capacity_limited_store_eviction #(
  parameter int unsigned SLOTS = cse_pkg::SlotsDefault
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  var cse_pkg::in_word_t     in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output cse_pkg::out_word_t        out_data_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [1:0]           cfg_idx_i,
  input  wire logic [31:0]          cfg_data_i
);
  localparam int unsigned SW = $clog2(SLOTS);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DEC   = 4'd1;
  localparam logic [3:0] S_SCAN  = 4'd2;
  localparam logic [3:0] S_VRD   = 4'd3;
  localparam logic [3:0] S_VWAIT = 4'd4;
  localparam logic [3:0] S_EVOUT = 4'd5;
  localparam logic [3:0] S_APPLY = 4'd6;
  localparam logic [3:0] S_FIN   = 4'd7;
  localparam logic [3:0] S_CHK   = 4'd8;
  localparam logic [3:0] S_SRD   = 4'd9;

  logic [3:0] state_q, state_d;

  logic [31:0] byte_limit_q;
  logic [5:0]  entry_limit_q;
  logic [2:0]  policy_q;

  logic [SLOTS-1:0] valid_q;
  logic [31:0] bytes_mem [SLOTS];
  logic [31:0] luse_mem  [SLOTS];
  logic [31:0] ucnt_mem  [SLOTS];
  logic [31:0] ins_mem   [SLOTS];

  logic [31:0] total_bytes_q, evictions_q, use_clock_q, insert_clock_q;
  logic [5:0]  total_entries_q;

  cse_pkg::in_word_t item_q;
  logic [SW-1:0] slot_idx;
  logic          slot_ok;

  logic [SW:0]   scan_q;
  logic [SW-1:0] ra_q;
  logic          rd_vld_q;
  logic [SW-1:0] rd_idx_q;
  logic [31:0]   rd_bytes_q, rd_luse_q, rd_ucnt_q, rd_ins_q;
  logic          have_q;
  logic [SW-1:0] best_q;
  logic [31:0]   bkey_q;
  logic [1:0]    status_q;
  logic [31:0]   self_bytes_q, self_ucnt_q, self_luse_q, self_ins_q;

  cse_pkg::out_word_t out_q;
  logic               out_v_q;

  assign slot_idx = SW'(item_q.slot);
  assign slot_ok  = {27'd0, item_q.slot} < 32'(SLOTS);

  // memory read port
  always_ff @(posedge clk_i) begin
    rd_bytes_q <= bytes_mem[ra_q];
    rd_luse_q  <= luse_mem[ra_q];
    rd_ucnt_q  <= ucnt_mem[ra_q];
    rd_ins_q   <= ins_mem[ra_q];
  end

  cse_pkg::cmp_req_t req;
  logic take;
  always_comb begin
    req.first  = !have_q;
    req.policy = policy_q;
    case (policy_q)
      cse_pkg::PolLru, cse_pkg::PolMru: req.key = use_clock_q - rd_luse_q;
      cse_pkg::PolLfu, cse_pkg::PolMfu: req.key = rd_ucnt_q;
      default:                          req.key = insert_clock_q - rd_ins_q;
    endcase
  end

  cse_cmp u_cmp (.req_i(req), .best_key_i(bkey_q), .take_o(take));

  logic cand;
  assign cand = rd_vld_q && valid_q[rd_idx_q] && (rd_idx_q != slot_idx);

  logic [32:0] need_sum;
  assign need_sum = {1'b0, total_bytes_q} + {1'b0, item_q.byte_count};

  logic fire_out;
  assign fire_out = out_v_q && !out_stall_i;

  logic out_free;
  assign out_free = !out_v_q || !out_stall_i;

  logic out_set;
  assign out_set = out_free && (state_q == S_EVOUT || state_q == S_FIN);

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  // writes into the per-slot memories
  logic          we;
  logic [SW-1:0] wa;
  logic [31:0]   w_bytes, w_luse, w_ucnt, w_ins;

  always_comb begin
    state_d = state_q;
    we = 1'b0;
    wa = slot_idx;
    w_bytes = '0;
    w_luse  = '0;
    w_ucnt  = '0;
    w_ins   = '0;
    case (state_q)
      S_IDLE:  if (in_valid_i) state_d = S_DEC;
      S_DEC:   state_d = S_SRD;
      S_SRD:   state_d = S_CHK;
      S_CHK: begin
        if (!slot_ok) begin
          state_d = S_FIN;
        end else begin
          case (item_q.op)
            cse_pkg::OpCreate: begin
              if (valid_q[slot_idx]) state_d = S_FIN;
              else if (total_entries_q >= entry_limit_q) state_d = S_SCAN;
              else state_d = S_APPLY;
            end
            cse_pkg::OpAdd: begin
              if (!valid_q[slot_idx]) state_d = S_FIN;
              else if (item_q.byte_count > byte_limit_q) state_d = S_FIN;
              else if (need_sum > {1'b0, byte_limit_q}) state_d = S_SCAN;
              else state_d = S_APPLY;
            end
            cse_pkg::OpAccess: state_d = valid_q[slot_idx] ? S_APPLY : S_FIN;
            default: state_d = S_FIN;
          endcase
        end
      end
      S_SCAN: begin
        if (scan_q == (SW+1)'(SLOTS) && !rd_vld_q) begin
          state_d = have_q ? S_VRD : S_FIN;
        end
      end
      S_VRD:   state_d = S_VWAIT;
      S_VWAIT: state_d = S_EVOUT;
      S_EVOUT: begin
        if (out_free) begin
          we = 1'b1;
          wa = best_q;
          if (item_q.op == cse_pkg::OpCreate) state_d = S_APPLY;
          else if (need_sum - {1'b0, rd_bytes_q} > {1'b0, byte_limit_q}) state_d = S_SCAN;
          else state_d = S_APPLY;
        end
      end
      S_APPLY: begin
        we = 1'b1;
        case (item_q.op)
          cse_pkg::OpCreate: begin
            w_luse = use_clock_q + 32'd1;
            w_ins  = insert_clock_q;
          end
          cse_pkg::OpAdd: begin
            w_bytes = self_bytes_q + item_q.byte_count;
            w_luse  = self_luse_q;
            w_ucnt  = self_ucnt_q;
            w_ins   = self_ins_q;
          end
          default: begin
            w_bytes = self_bytes_q;
            w_luse  = use_clock_q + 32'd1;
            w_ucnt  = self_ucnt_q + 32'd1;
            w_ins   = self_ins_q;
          end
        endcase
        state_d = S_FIN;
      end
      S_FIN:   if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      bytes_mem[wa] <= w_bytes;
      luse_mem[wa]  <= w_luse;
      ucnt_mem[wa]  <= w_ucnt;
      ins_mem[wa]   <= w_ins;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) item_q <= in_data_i;
    if (state_q == S_CHK) begin
      self_bytes_q <= rd_bytes_q;
      self_ucnt_q  <= rd_ucnt_q;
      self_luse_q  <= rd_luse_q;
      self_ins_q   <= rd_ins_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      byte_limit_q    <= cse_pkg::ByteLimitReset;
      entry_limit_q   <= cse_pkg::EntryLimitReset;
      policy_q        <= cse_pkg::PolFifo;
      valid_q         <= '0;
      total_bytes_q   <= '0;
      total_entries_q <= '0;
      evictions_q     <= '0;
      use_clock_q     <= '0;
      insert_clock_q  <= '0;
      scan_q          <= '0;
      ra_q            <= '0;
      rd_vld_q        <= 1'b0;
      rd_idx_q        <= '0;
      have_q          <= 1'b0;
      best_q          <= '0;
      bkey_q          <= '0;
      status_q        <= cse_pkg::StOk;
      out_v_q         <= 1'b0;
      out_q           <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          cse_pkg::CfgByteLimit:  byte_limit_q  <= cfg_data_i;
          cse_pkg::CfgEntryLimit: entry_limit_q <= cfg_data_i[5:0];
          cse_pkg::CfgPolicy:     policy_q      <= cfg_data_i[2:0];
          default: ;
        endcase
      end
      if (out_set) out_v_q <= 1'b1;
      else if (fire_out) out_v_q <= 1'b0;
      rd_vld_q <= (state_q == S_SCAN) && (scan_q != (SW+1)'(SLOTS));
      case (state_q)
        S_DEC: begin
          status_q <= cse_pkg::StOk;
          ra_q     <= slot_idx;
        end
        S_CHK: begin
          scan_q <= '0;
          have_q <= 1'b0;
          ra_q   <= '0;
          if (slot_ok && item_q.op == cse_pkg::OpAdd && valid_q[slot_idx]
              && item_q.byte_count > byte_limit_q) status_q <= cse_pkg::StTooBig;
        end
        S_SCAN: begin
          if (scan_q != (SW+1)'(SLOTS)) begin
            rd_idx_q <= scan_q[SW-1:0];
            scan_q   <= scan_q + 1'b1;
            if (scan_q + 1'b1 != (SW+1)'(SLOTS)) ra_q <= SW'(scan_q + 1'b1);
          end
          if (cand && take) begin
            have_q <= 1'b1;
            best_q <= rd_idx_q;
            bkey_q <= req.key;
          end
          if (scan_q == (SW+1)'(SLOTS) && !rd_vld_q) begin
            if (!have_q) status_q <= cse_pkg::StNoVict;
            ra_q <= best_q;
          end
        end
        S_EVOUT: begin
          if (out_free) begin
            valid_q[best_q]  <= 1'b0;
            total_bytes_q    <= total_bytes_q - rd_bytes_q;
            total_entries_q  <= total_entries_q - 6'd1;
            evictions_q      <= evictions_q + 32'd1;
            out_q.kind           <= 1'b0;
            out_q.victim_slot    <= 5'(best_q);
            out_q.victim_bytes   <= rd_bytes_q;
            out_q.last           <= 1'b0;
            out_q.status         <= cse_pkg::StOk;
            out_q.bytes_in_use   <= total_bytes_q - rd_bytes_q;
            out_q.entries_in_use <= total_entries_q - 6'd1;
            out_q.eviction_total <= evictions_q + 32'd1;
            scan_q <= '0;
            have_q <= 1'b0;
            ra_q   <= '0;
          end
        end
        S_APPLY: begin
          case (item_q.op)
            cse_pkg::OpCreate: begin
              valid_q[slot_idx] <= 1'b1;
              use_clock_q       <= use_clock_q + 32'd1;
              insert_clock_q    <= insert_clock_q + 32'd1;
              total_entries_q   <= total_entries_q + 6'd1;
            end
            cse_pkg::OpAdd: total_bytes_q <= total_bytes_q + item_q.byte_count;
            default: use_clock_q <= use_clock_q + 32'd1;
          endcase
        end
        S_FIN: begin
          if (out_free) begin
            out_q.kind           <= 1'b1;
            out_q.victim_slot    <= '0;
            out_q.victim_bytes   <= '0;
            out_q.last           <= 1'b1;
            out_q.status         <= status_q;
            out_q.bytes_in_use   <= total_bytes_q;
            out_q.entries_in_use <= total_entries_q;
            out_q.eviction_total <= evictions_q;
          end
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire
